// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files of the UTF-8 decoder.
// Depends on a clk and an arst_n signal visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/u8u2_pkg.sv =====
// Types and constants of the UTF-8 to UCS-2 decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package u8u2_pkg;

	// Result unit for a four- to six-byte sequence
	localparam logic [15:0] UNIT_LONG_FORM = 16'hff1f;

	// Byte order mark bytes
	localparam logic [7:0] MARK_FIRST  = 8'hef;
	localparam logic [7:0] MARK_SECOND = 8'hbb;
	localparam logic [7:0] MARK_THIRD  = 8'hbf;

	// Continuation counts
	localparam logic [2:0] LEFT_NONE  = 3'd0;
	localparam logic [2:0] LEFT_ONE   = 3'd1;
	localparam logic [2:0] LEFT_TWO   = 3'd2;
	localparam logic [2:0] LEFT_THREE = 3'd3;
	localparam logic [2:0] LEFT_FOUR  = 3'd4;
	localparam logic [2:0] LEFT_FIVE  = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        has_unit;
		logic        error;
		logic        end_of_string;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  bytes_left;
		logic [15:0] accumulated_unit;
		logic        skipping_long_form;
		logic        in_first_sequence;
		logic        mark_still_matching;
		logic        aborted;
	} dec_state_t;

	localparam dec_state_t STATE_RESET = '{
		bytes_left:          LEFT_NONE,
		accumulated_unit:    16'h0000,
		skipping_long_form:  1'b0,
		in_first_sequence:   1'b1,
		mark_still_matching: 1'b0,
		aborted:             1'b0
	};

endpackage

`default_nettype wire

// ===== sv/utf8_to_ucs2_decoder_unit.sv =====
// UTF-8 to UCS-2 decoder: one UTF-8 byte per request in, zero or one unit out.
// Depends on u8u2_pkg and u8u2_step.
//
// Usage:
//   Input channel in_valid/in_ready/in_payload carries one byte and a flag
//   marking the last byte of a string. Output channel out_valid/out_ready/
//   out_payload carries a 16-bit code unit with has_unit, error and
//   end_of_string flags. The last byte of a string always yields one
//   request with end_of_string set; other bytes yield a request only when
//   they produce a unit (a leading byte order mark yields none).
//   A result appears on the output in the cycle after its byte is
//   accepted. Throughput: one byte per cycle, set by the single decode
//   step between the state registers and the output register.
//   Stall: while the output register holds a request that is not taken,
//   in_ready is low; in_ready stays high when the register is empty or is
//   being drained in the same cycle, so a stream stalls only on out_ready.
//   Reset: arst_n empties the output register and returns the decoder to
//   the start of a string; no clearing pass is needed.
`default_nettype none

module utf8_to_ucs2_decoder_unit
	import u8u2_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  wire in_item_t in_payload,
	output logic          out_valid,
	input  wire           out_ready,
	output out_item_t     out_payload
);

	dec_state_t state_q;
	dec_state_t state_next;
	logic       emit;
	out_item_t  result;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       in_accept;

	// Accept when the output register is free or drains this cycle
	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	u8u2_step u_step (
		.state      (state_q),
		.item       (in_payload),
		.state_next (state_next),
		.emit       (emit),
		.result     (result)
	);

	// Advance decoder state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (in_accept) begin
			state_q <= state_next;
		end
	end

	// Hold the output request until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && emit) begin
			out_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_payload = out_q;

endmodule

`default_nettype wire

// ===== sv/u8u2_step.sv =====
// Per-byte decode logic: next decoder state and the result of one byte.
// Depends on u8u2_pkg; purely combinational.
`default_nettype none

module u8u2_step
	import u8u2_pkg::*;
(
	input  wire dec_state_t state,
	input  wire in_item_t   item,
	output dec_state_t      state_next,
	output logic            emit,
	output out_item_t       result
);

	logic [7:0]  b;
	logic [2:0]  left_dec;
	logic        has;
	logic [15:0] unit;
	dec_state_t  nx;

	assign b        = item.data_byte;
	assign left_dec = state.bytes_left - LEFT_ONE;

	// Advance the sequence state for one byte
	always_comb begin
		nx   = state;
		has  = 1'b0;
		unit = 16'h0000;
		if (state.aborted) begin
			nx = state;
		end else if (state.bytes_left != LEFT_NONE) begin
			if (!state.skipping_long_form) begin
				if (state.bytes_left == LEFT_TWO) begin
					nx.accumulated_unit = state.accumulated_unit | {4'b0, b[5:0], 6'b0};
					if (b != MARK_SECOND) begin
						nx.mark_still_matching = 1'b0;
					end
				end else begin
					nx.accumulated_unit = state.accumulated_unit | {10'b0, b[5:0]};
				end
			end
			nx.bytes_left = left_dec;
			if (left_dec == LEFT_NONE) begin
				if (!state.skipping_long_form &&
					!(nx.mark_still_matching && b == MARK_THIRD)) begin
					has  = 1'b1;
					unit = nx.accumulated_unit;
				end
				nx.skipping_long_form  = 1'b0;
				nx.mark_still_matching = 1'b0;
			end
		end else begin
			nx.mark_still_matching = 1'b0;
			if (b < 8'h80) begin
				has  = 1'b1;
				unit = {8'h00, b};
			end else if (b < 8'hc0) begin
				nx.aborted = 1'b1;
			end else if (b < 8'he0) begin
				nx.accumulated_unit = {5'b0, b[4:0], 6'b0};
				nx.bytes_left       = LEFT_ONE;
			end else if (b < 8'hf0) begin
				nx.accumulated_unit    = {b[3:0], 12'h000};
				nx.bytes_left          = LEFT_TWO;
				nx.mark_still_matching = state.in_first_sequence && (b == MARK_FIRST);
			end else if (b < 8'hfe) begin
				has                   = 1'b1;
				unit                  = UNIT_LONG_FORM;
				nx.skipping_long_form = 1'b1;
				if (b < 8'hf8) begin
					nx.bytes_left = LEFT_THREE;
				end else if (b < 8'hfc) begin
					nx.bytes_left = LEFT_FOUR;
				end else begin
					nx.bytes_left = LEFT_FIVE;
				end
			end else begin
				nx.aborted = 1'b1;
			end
		end
		nx.in_first_sequence = 1'b0;
	end

	// Close the string on its last byte, flushing a truncated sequence
	always_comb begin
		state_next = nx;
		emit       = has;
		result     = '{code_unit: unit, has_unit: has, error: 1'b0, end_of_string: 1'b0};
		if (item.last_byte) begin
			emit       = 1'b1;
			state_next = STATE_RESET;
			if (!nx.aborted && nx.bytes_left != LEFT_NONE && !nx.skipping_long_form) begin
				result.has_unit  = 1'b1;
				result.code_unit = nx.accumulated_unit;
			end
			result.error         = nx.aborted;
			result.end_of_string = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== sv/u8u2_checker.sv =====
// Port-level checks of the UTF-8 to UCS-2 decoder, bound to its top level.
// Depends on u8u2_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module u8u2_checker
	import u8u2_pkg::*;
(
	input wire            clk,
	input wire            arst_n,
	input wire            in_valid,
	input wire            in_ready,
	input wire in_item_t  in_payload,
	input wire            out_valid,
	input wire            out_ready,
	input wire out_item_t out_payload
);

	// Stalled request holds
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "output request changed while stalled")

	// Empty output register never blocks the input
	`ASSERT_NOW(a_in_ready_free, !out_valid, in_ready, "input blocked with empty output")

	// Unit is zero when none is carried
	`ASSERT_NOW(a_unit_zero, out_valid && !out_payload.has_unit, out_payload.code_unit == 16'h0000, "code unit set without has_unit")

	// Error is only reported at end of string
	`ASSERT_NOW(a_err_eos, out_valid && out_payload.error, out_payload.end_of_string && !out_payload.has_unit, "error outside end of string")

	// Last byte always produces a request next cycle
	`ASSERT_NEXT(a_last_emits, in_valid && in_ready && in_payload.last_byte, out_valid && out_payload.end_of_string, "last byte gave no end of string")

endmodule

bind utf8_to_ucs2_decoder_unit u8u2_checker u_checker (.*);

`default_nettype wire
